// File: sv/bfct_pkg.sv
// Shared constants and types for the box frustum corner test.
package bfct_pkg;

  // Matrix entries are two's complement Q16.16 words.
  localparam int MAT_W = 32;
  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 4;
  localparam int NUM_CORNERS = 8;

  // Growth of the clip sum over a single product: three products and a constant.
  localparam int SUM_GROW = 2;
  // Growth of the near-plane term: 10000 fits in 14 bits.
  localparam int NEAR_GROW = 14;

  // Configuration port geometry: 64-bit registers at byte address 8*i.
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int REG_IDX_W = 3;
  localparam int NUM_REGS = 8;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_R0_C01 = 3'd0,
    REG_R0_C23 = 3'd1,
    REG_R1_C01 = 3'd2,
    REG_R1_C23 = 3'd3,
    REG_R2_C01 = 3'd4,
    REG_R2_C23 = 3'd5,
    REG_R3_C01 = 3'd6,
    REG_R3_C23 = 3'd7
  } cfg_reg_e;

endpackage

// File: sv/bfct_box_if.sv
// Valid/ready channel that carries one box as two opposite corners.
interface bfct_box_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_x_lo;
  logic signed [COORD_BITS-1:0] box_y_lo;
  logic signed [COORD_BITS-1:0] box_z_lo;
  logic signed [COORD_BITS-1:0] box_x_hi;
  logic signed [COORD_BITS-1:0] box_y_hi;
  logic signed [COORD_BITS-1:0] box_z_hi;

  modport source (
    output valid, box_x_lo, box_y_lo, box_z_lo, box_x_hi, box_y_hi, box_z_hi,
    input  ready
  );
  modport sink (
    input  valid, box_x_lo, box_y_lo, box_z_lo, box_x_hi, box_y_hi, box_z_hi,
    output ready
  );
endinterface

// File: sv/bfct_res_if.sv
// Valid/ready channel that carries one culling result.
interface bfct_res_if;
  import bfct_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   any_inside;
  logic [NUM_CORNERS-1:0] corner_hits;

  modport source (
    output valid, any_inside, corner_hits,
    input  ready
  );
  modport sink (
    input  valid, any_inside, corner_hits,
    output ready
  );
endinterface

// File: sv/box_frustum_corner_test.sv
// Top level of the box frustum corner test: configuration registers and the transform pipeline.
//
// Usage: a box enters on box_in as two opposite signed integer corners. The eight corners
// are transformed by the 4x4 Q16.16 matrix held in eight 64-bit registers written over the
// APB-style port (register i at byte address 8*i, bits 31:0 hold the even column and bits
// 63:32 the odd column). A corner counts as inside when w > 0, 10000 z >= 9 w, and x and y
// lie within [-w, w]. Each box gives exactly one result transaction on res_out: a mask of
// inside corners and a flag that is set when any corner is inside.
// Throughput is one box per cycle while the receiver takes results. The pipeline has five
// register stages (products, pairwise sums, clip sums, near-plane scaling, output register).
// Each stage holds a valid bit and advances when its successor has room, so bubbles close up
// and a box is still accepted while a finished result waits. When the receiver stalls, the
// stages fill one by one and box_in.ready falls only when all five hold a transaction.
// Reset clears the valid bits and the matrix; a zero matrix gives w = 0, so every corner
// reads as outside until the matrix is written. The user must write the matrix only while
// idle; the block itself does not enforce it.
// COORD_BITS must match the parameter of the box_in interface instance.
module box_frustum_corner_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfct_pkg::ADDR_W-1:0]   paddr,
  input  logic [bfct_pkg::DATA_W-1:0]   pwdata,
  output logic [bfct_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  bfct_box_if.sink                      box_in,
  bfct_res_if.source                    res_out
);
  import bfct_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int PW = MAT_W + CW;   // one matrix-by-coordinate product
  localparam int XW = PW + 1;       // sum of two terms
  localparam int SW = PW + SUM_GROW; // full clip coordinate

  // Configuration registers.
  logic [DATA_W-1:0] cfg_q [NUM_REGS];
  cfg_reg_e          reg_idx;

  assign reg_idx = cfg_reg_e'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);
  assign pready  = 1'b1;
  assign prdata  = cfg_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      cfg_q[reg_idx] <= pwdata;
    end
  end

  // Matrix entries, split from the row registers.
  logic [DATA_W-1:0]       row_c01 [NUM_ROWS];
  logic [DATA_W-1:0]       row_c23 [NUM_ROWS];
  logic signed [MAT_W-1:0] mat [NUM_ROWS][NUM_COLS];

  assign row_c01[0] = cfg_q[REG_R0_C01];
  assign row_c23[0] = cfg_q[REG_R0_C23];
  assign row_c01[1] = cfg_q[REG_R1_C01];
  assign row_c23[1] = cfg_q[REG_R1_C23];
  assign row_c01[2] = cfg_q[REG_R2_C01];
  assign row_c23[2] = cfg_q[REG_R2_C23];
  assign row_c01[3] = cfg_q[REG_R3_C01];
  assign row_c23[3] = cfg_q[REG_R3_C23];

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_mat
    assign mat[r][0] = row_c01[r][MAT_W-1:0];
    assign mat[r][1] = row_c01[r][DATA_W-1:MAT_W];
    assign mat[r][2] = row_c23[r][MAT_W-1:0];
    assign mat[r][3] = row_c23[r][DATA_W-1:MAT_W];
  end

  // Pipeline flow control: a stage advances when it is empty or its successor advances.
  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic en_a, en_b, en_c, en_d, en_e;

  assign en_e = !ve_q || res_out.ready;
  assign en_d = !vd_q || en_e;
  assign en_c = !vc_q || en_d;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign box_in.ready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= box_in.valid;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
      if (en_c) begin
        vc_q <= vb_q;
      end
      if (en_d) begin
        vd_q <= vc_q;
      end
      if (en_e) begin
        ve_q <= vd_q;
      end
    end
  end

  // Coordinates by axis (x multiplies column 0, y column 1, z column 2) and side (lo, hi).
  logic signed [CW-1:0] crd [3][2];

  assign crd[0][0] = box_in.box_x_lo;
  assign crd[0][1] = box_in.box_x_hi;
  assign crd[1][0] = box_in.box_y_lo;
  assign crd[1][1] = box_in.box_y_hi;
  assign crd[2][0] = box_in.box_z_lo;
  assign crd[2][1] = box_in.box_z_hi;

  // Stage A: every matrix entry times both values of its coordinate (24 products).
  logic signed [PW-1:0] prod_q [NUM_ROWS][3][2];

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < 3; c++) begin
          for (int s = 0; s < 2; s++) begin
            prod_q[r][c][s] <= PW'(mat[r][c] * crd[c][s]);
          end
        end
      end
    end
  end

  // Stage B: x plus y terms for the four x/y side pairs, and z term plus the row constant.
  logic signed [XW-1:0] xy_q [NUM_ROWS][2][2];
  logic signed [XW-1:0] zc_q [NUM_ROWS][2];

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int sx = 0; sx < 2; sx++) begin
          for (int sy = 0; sy < 2; sy++) begin
            xy_q[r][sx][sy] <= XW'(prod_q[r][0][sx]) + XW'(prod_q[r][1][sy]);
          end
        end
        for (int sz = 0; sz < 2; sz++) begin
          zc_q[r][sz] <= XW'(prod_q[r][2][sz]) + XW'(mat[r][3]);
        end
      end
    end
  end

  // Stage C: full clip coordinates of each corner. Bit 0 of the corner number picks x,
  // bit 1 picks z and bit 2 picks y.
  logic signed [SW-1:0] clip_q [NUM_CORNERS][NUM_ROWS];

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          clip_q[k][r] <= SW'(xy_q[r][k[0]][k[2]]) + SW'(zc_q[r][k[1]]);
        end
      end
    end
  end

  // Stage D lives in the per-corner test units; their compare feeds the output register.
  logic [NUM_CORNERS-1:0] hits;

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
    bfct_clip_test #(
      .CLIP_W (SW)
    ) u_clip_test (
      .clk_i (clk_i),
      .en_i  (en_d),
      .cx_i  (clip_q[k][0]),
      .cy_i  (clip_q[k][1]),
      .cz_i  (clip_q[k][2]),
      .cw_i  (clip_q[k][3]),
      .hit_o (hits[k])
    );
  end

  // Stage E: output register.
  logic [NUM_CORNERS-1:0] hits_q;
  logic                   any_q;

  always_ff @(posedge clk_i) begin
    if (en_e) begin
      hits_q <= hits;
      any_q  <= |hits;
    end
  end

  assign res_out.valid       = ve_q;
  assign res_out.corner_hits = hits_q;
  assign res_out.any_inside  = any_q;

  // An accepted box always occupies the first stage on the next cycle.
  property p_accept_fills;
    @(posedge clk_i) disable iff (!rst_ni)
      (box_in.valid && box_in.ready) |=> va_q;
  endproperty
  a_accept_fills: assert property (p_accept_fills)
    else $error("accepted box did not reach the product stage");

  // A held clip-sum transaction is never dropped while the stage behind it is stalled.
  property p_stall_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      (vc_q && !en_d) |=> (vc_q && $stable(clip_q[0][3]));
  endproperty
  a_stall_holds: assert property (p_stall_holds)
    else $error("clip stage lost its transaction during a stall");

  // The summary flag agrees with the corner mask on every result.
  property p_any_matches;
    @(posedge clk_i) disable iff (!rst_ni)
      res_out.valid |-> (res_out.any_inside == (|res_out.corner_hits));
  endproperty
  a_any_matches: assert property (p_any_matches)
    else $error("any_inside disagrees with corner_hits");

  // With all five stages full and the receiver stalled, no new box is taken.
  property p_full_blocks;
    @(posedge clk_i) disable iff (!rst_ni)
      (va_q && vb_q && vc_q && vd_q && ve_q && !res_out.ready) |-> !box_in.ready;
  endproperty
  a_full_blocks: assert property (p_full_blocks)
    else $error("box accepted while the pipeline was full");

endmodule

// File: sv/bfct_clip_test.sv
// Clip-space inside test of one corner: one register stage plus the final compare.
module bfct_clip_test #(
  parameter int CLIP_W = 50
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [CLIP_W-1:0] cx_i,
  input  logic signed [CLIP_W-1:0] cy_i,
  input  logic signed [CLIP_W-1:0] cz_i,
  input  logic signed [CLIP_W-1:0] cw_i,
  output logic                     hit_o
);
  import bfct_pkg::*;

  localparam int NW = CLIP_W + NEAR_GROW;
  localparam int EW = CLIP_W + 1;

  logic signed [NW-1:0] cz_ext;
  logic signed [NW-1:0] cw_ext;
  logic signed [NW-1:0] near_lhs_d, near_lhs_q;
  logic signed [NW-1:0] near_rhs_d, near_rhs_q;
  logic signed [EW-1:0] sum_x, dif_x, sum_y, dif_y;
  logic                 flag_d, flag_q;

  assign cz_ext = NW'(cz_i);
  assign cw_ext = NW'(cw_i);

  // The near test z >= 0.0009 w is done as 10000 z >= 9 w.
  // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4, and 9 = 2^3 + 1.
  assign near_lhs_d = ((cz_ext <<< 13) + (cz_ext <<< 10))
                    + ((cz_ext <<< 9) + (cz_ext <<< 8))
                    + (cz_ext <<< 4);
  assign near_rhs_d = (cw_ext <<< 3) + cw_ext;

  assign sum_x = EW'(cx_i) + EW'(cw_i);
  assign dif_x = EW'(cw_i) - EW'(cx_i);
  assign sum_y = EW'(cy_i) + EW'(cw_i);
  assign dif_y = EW'(cw_i) - EW'(cy_i);

  assign flag_d = !cw_i[CLIP_W-1] && (cw_i != '0)
               && !sum_x[EW-1] && !dif_x[EW-1]
               && !sum_y[EW-1] && !dif_y[EW-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      near_lhs_q <= near_lhs_d;
      near_rhs_q <= near_rhs_d;
      flag_q     <= flag_d;
    end
  end

  assign hit_o = flag_q && (near_lhs_q >= near_rhs_q);

endmodule

// File: test/testbench.sv
// Self-checking testbench for the box frustum corner test: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

typedef logic signed [15:0] coord_t;

typedef struct {
  coord_t x_lo;
  coord_t y_lo;
  coord_t z_lo;
  coord_t x_hi;
  coord_t y_hi;
  coord_t z_hi;
} box_t;

typedef struct packed {
  logic                             any_inside;
  logic [bfct_pkg::NUM_CORNERS-1:0] corner_hits;
} cull_res_t;

// Keeps its own copy of the matrix, predicts the culling result of every accepted box
// and compares the results that come out of the block against those predictions in order.
class cull_scoreboard;
  logic signed [31:0] coef [4][4];
  cull_res_t          expected_q [$];
  int                 mismatches;

  function new();
    foreach (coef[i, j]) coef[i][j] = '0;
    mismatches = 0;
  endfunction

  // Register index i holds row i/2; its low word is the even column, its high word the odd one.
  function void write_reg(int idx, logic [63:0] value);
    int row;
    int col;
    row = idx / 2;
    col = (idx % 2) * 2;
    coef[row][col]     = value[31:0];
    coef[row][col + 1] = value[63:32];
  endfunction

  // Exact clip-space test of all eight corners. 80 bits hold every product and sum,
  // including the near-plane scaling by 10000, without overflow.
  function cull_res_t cull_box(box_t b);
    logic signed [79:0] pt   [4];
    logic signed [79:0] clip [4];
    logic signed [79:0] coef_w;
    cull_res_t          res;
    res.corner_hits = '0;
    for (int k = 0; k < 8; k++) begin
      // Corner order: bit 0 picks x, bit 1 picks z, bit 2 picks y.
      pt[0] = k[0] ? b.x_hi : b.x_lo;
      pt[1] = k[2] ? b.y_hi : b.y_lo;
      pt[2] = k[1] ? b.z_hi : b.z_lo;
      pt[3] = 80'sd1;
      for (int row = 0; row < 4; row++) begin
        clip[row] = '0;
        for (int col = 0; col < 4; col++) begin
          coef_w    = coef[row][col];
          clip[row] = clip[row] + coef_w * pt[col];
        end
      end
      // Near plane z >= 0.0009 w, tested as 10000 z >= 9 w.
      if (clip[3] > 0 && clip[2] * 10000 >= clip[3] * 9 &&
          clip[0] + clip[3] >= 0 && clip[3] - clip[0] >= 0 &&
          clip[1] + clip[3] >= 0 && clip[3] - clip[1] >= 0) begin
        res.corner_hits[k] = 1'b1;
      end
    end
    res.any_inside = |res.corner_hits;
    return res;
  endfunction

  function void note_box(box_t b);
    expected_q.insert(expected_q.size(), cull_box(b));
  endfunction

  function void check_result(logic any_inside, logic [bfct_pkg::NUM_CORNERS-1:0] corner_hits);
    cull_res_t exp_res;
    if (expected_q.size() == 0) begin
      $display("%0t: result with no box waiting, actual any_inside %b corner_hits %02h",
               $time, any_inside, corner_hits);
      mismatches++;
      return;
    end
    exp_res = expected_q.pop_front();
    if (any_inside !== exp_res.any_inside) begin
      $display("%0t: any_inside mismatch, expected %b, actual %b",
               $time, exp_res.any_inside, any_inside);
      mismatches++;
    end
    if (corner_hits !== exp_res.corner_hits) begin
      $display("%0t: corner_hits mismatch, expected %02h, actual %02h",
               $time, exp_res.corner_hits, corner_hits);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module testbench;
  import bfct_pkg::*;

  localparam int COORD_BITS = 16;
  // One Q16.16 unit.
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  // Matrix settings that the run steps through. The two constant ones are the extremes
  // of the entry range; the zero matrix after reset is the third extreme.
  typedef enum int {
    MAT_PYRAMID,
    MAT_NEAR,
    MAT_SHIFTED,
    MAT_RAND_SMALL,
    MAT_RAND_FULL,
    MAT_ALL_MAX,
    MAT_ALL_MIN
  } mat_kind_e;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  bfct_box_if #(.COORD_BITS(COORD_BITS)) box_ch ();
  bfct_res_if                            res_ch ();

  cull_scoreboard sb;

  // Chance in percent that the sender idles in a given cycle, and that the
  // receiver holds ready low in a given cycle.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  logic [31:0] mat [4][4];

  box_frustum_corner_test #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .box_in  (box_ch),
    .res_out (res_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run; a correct run ends long before this.
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // The receiver decides at every falling edge whether it takes a result in the next cycle,
  // so stalls land on every phase of the pipeline.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result monitor: every transaction on the result channel is checked against the
  // oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      sb.check_result(res_ch.any_inside, res_ch.corner_hits);
    end
  end

  function automatic box_t make_box(int xl, int yl, int zl, int xh, int yh, int zh);
    box_t b;
    b.x_lo = coord_t'(xl);
    b.y_lo = coord_t'(yl);
    b.z_lo = coord_t'(zl);
    b.x_hi = coord_t'(xh);
    b.y_hi = coord_t'(yh);
    b.z_hi = coord_t'(zh);
    return b;
  endfunction

  // Most boxes sit around the view volume of the pyramid-style matrices so that corners
  // fall on both sides of every plane; a quarter use the full coordinate range.
  function automatic box_t rand_box();
    box_t b;
    if ($urandom_range(0, 99) < 25) begin
      b.x_lo = coord_t'($urandom_range(0, 65535));
      b.y_lo = coord_t'($urandom_range(0, 65535));
      b.z_lo = coord_t'($urandom_range(0, 65535));
      b.x_hi = coord_t'($urandom_range(0, 65535));
      b.y_hi = coord_t'($urandom_range(0, 65535));
      b.z_hi = coord_t'($urandom_range(0, 65535));
    end else begin
      b.x_lo = coord_t'(int'($urandom_range(0, 400)) - 200);
      b.y_lo = coord_t'(int'($urandom_range(0, 400)) - 200);
      b.z_lo = coord_t'(int'($urandom_range(0, 400)) - 50);
      // An offset below zero gives a reversed box on that axis.
      b.x_hi = b.x_lo + coord_t'(int'($urandom_range(0, 120)) - 30);
      b.y_hi = b.y_lo + coord_t'(int'($urandom_range(0, 120)) - 30);
      b.z_hi = b.z_lo + coord_t'(int'($urandom_range(0, 120)) - 30);
    end
    return b;
  endfunction

  // Offers one box, waits for the handshake, records it, and then perhaps idles.
  // Called right after a falling edge; returns right after one. valid stays high
  // between back-to-back transactions.
  task automatic send_box(box_t b);
    box_ch.valid    <= 1'b1;
    box_ch.box_x_lo <= b.x_lo;
    box_ch.box_y_lo <= b.y_lo;
    box_ch.box_z_lo <= b.z_lo;
    box_ch.box_x_hi <= b.x_hi;
    box_ch.box_y_hi <= b.y_hi;
    box_ch.box_z_hi <= b.z_hi;
    @(posedge clk_i);
    while (!box_ch.ready) @(posedge clk_i);
    sb.note_box(b);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      box_ch.valid <= 1'b0;
      do begin
        @(negedge clk_i);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  // Stops sending and waits until every predicted result has come out, then lets the
  // five-stage pipeline run empty with some margin.
  task automatic drain();
    if (box_ch.valid) box_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One register write (setup and access phase) followed by a read back of the same
  // register. The scoreboard copy is updated at the edge that takes the write.
  task automatic cfg_write(cfg_reg_e idx, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(int'(idx), value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) begin
      $display("%0t: register %s read back mismatch, expected %016h, actual %016h",
               $time, idx.name(), value, readback);
      sb.mismatches++;
    end
    // The bus idles before the next access.
    @(negedge clk_i);
  endtask

  // Fills the matrix for the chosen setting and writes all eight registers.
  task automatic load_matrix(mat_kind_e kind);
    foreach (mat[i, j]) mat[i][j] = '0;
    case (kind)
      MAT_PYRAMID: begin
        // Clip x = x, y = y, z = w = z: a 90 degree pyramid along +z.
        mat[0][0] = Q_ONE;
        mat[1][1] = Q_ONE;
        mat[2][2] = Q_ONE;
        mat[3][2] = Q_ONE;
      end
      MAT_NEAR: begin
        // Fractional x scale and a z offset that puts the near plane close to z = 50.
        mat[0][0] = 32'h0001_8000;
        mat[1][1] = 32'h0002_0000;
        mat[2][2] = Q_ONE;
        mat[2][3] = 32'hFFCE_0000;
        mat[3][2] = Q_ONE;
      end
      MAT_SHIFTED: begin
        // Translated and slightly sheared frustum, with w offset.
        mat[0][0] = Q_ONE;
        mat[0][2] = 32'h0000_4000;
        mat[0][3] = 32'h0064_0000;
        mat[1][1] = Q_ONE;
        mat[1][3] = 32'hFF9C_0000;
        mat[2][2] = Q_ONE;
        mat[3][2] = Q_ONE;
        mat[3][3] = 32'h0032_0000;
      end
      MAT_RAND_SMALL: begin
        // Entries within +-2.0, with w kept leaning on z so that hits still occur.
        foreach (mat[i, j]) mat[i][j] = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
        mat[3][2] = Q_ONE + ($urandom_range(0, 32'h0000_FFFF) - 32'h0000_8000);
      end
      MAT_RAND_FULL: begin
        foreach (mat[i, j]) mat[i][j] = $urandom();
      end
      MAT_ALL_MAX: begin
        foreach (mat[i, j]) mat[i][j] = 32'h7FFF_FFFF;
      end
      MAT_ALL_MIN: begin
        foreach (mat[i, j]) mat[i][j] = 32'h8000_0000;
      end
      default: ;
    endcase
    for (int row = 0; row < NUM_ROWS; row++) begin
      cfg_write(cfg_reg_e'(row * 2),     {mat[row][1], mat[row][0]});
      cfg_write(cfg_reg_e'(row * 2 + 1), {mat[row][3], mat[row][2]});
    end
  endtask

  initial begin : stimulus
    mat_kind_e plan [7];
    plan = '{MAT_PYRAMID, MAT_SHIFTED, MAT_ALL_MAX, MAT_RAND_SMALL,
             MAT_NEAR, MAT_ALL_MIN, MAT_RAND_FULL};

    sb = new();
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    box_ch.valid    = 1'b0;
    box_ch.box_x_lo = '0;
    box_ch.box_y_lo = '0;
    box_ch.box_z_lo = '0;
    box_ch.box_x_hi = '0;
    box_ch.box_y_hi = '0;
    box_ch.box_z_hi = '0;
    send_idle_pct   = 19;
    recv_idle_pct   = 84;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // With the matrix still at its reset value, w is zero and nothing may hit,
    // even for the coordinate extremes.
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
    send_box(make_box(0, 0, 1, 0, 0, 1));

    drain();
    load_matrix(MAT_PYRAMID);
    // Degenerate box strictly inside: all eight corners hit.
    send_box(make_box(0, 0, 1, 0, 0, 1));
    // Corners exactly on the side planes x = +-w and y = +-w.
    send_box(make_box(-5, -5, 5, 5, 5, 5));
    // Reversed box just outside the side planes.
    send_box(make_box(6, 0, 5, -6, 0, 5));
    // Straddles w = 0: only the far corners are inside.
    send_box(make_box(-10, -10, -10, 10, 10, 10));
    // The origin has w = 0 and is outside.
    send_box(make_box(0, 0, 0, 0, 0, 0));
    // Box behind the eye, where w is negative.
    send_box(make_box(-1, -1, -3, 1, 1, -1));
    // Field extremes in mixed combinations.
    send_box(make_box(-32768, 32767, 32767, 32767, -32768, -32768));
    send_box(make_box(32767, -32768, 32767, -32768, 32767, 32767));
    send_box(make_box(0, 0, 32767, -32768, 32767, 32767));

    drain();
    load_matrix(MAT_NEAR);
    // Near plane: z = 50 lies in front of it, z = 51 behind it.
    send_box(make_box(0, 0, 50, 0, 0, 51));
    send_box(make_box(-34, -25, 51, 34, 25, 51));
    send_box(make_box(-35, -26, 60, 35, 26, 60));
    send_box(make_box(32767, 32767, 32767, -32768, -32768, 32767));

    // Random boxes under a series of matrices. The idle pattern changes between the
    // three groups of settings: sender idles rarely and receiver often, then the reverse,
    // then both run flat out.
    for (int blk = 0; blk < 7; blk++) begin
      drain();
      if (blk == 3) begin
        send_idle_pct = 84;
        recv_idle_pct = 19;
      end else if (blk == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_matrix(plan[blk]);
      for (int n = 0; n < 120; n++) begin
        // Once in the run, hold off until the pipeline has emptied completely.
        if (blk == 3 && n == 60) drain();
        send_box(rand_box());
      end
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
